// ===== src/sstc_pkg.sv =====
// Shared types, constants and the arctangent table for the sensor skew unit.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package sstc_pkg;

   localparam int DIST_W        = 16;
   localparam int CFG_W         = 16;
   localparam int XY_W          = DIST_W + 20;
   localparam int Z_W           = 25;
   localparam int ANGLE_W       = 16;
   localparam int COUNT_W       = 15;
   localparam int ATAN_ENTRIES  = 24;
   localparam int CORDIC_STAGES = 16;
   localparam int FRAC_SHIFT    = 16;
   localparam int ROUND_SHIFT   = 8;
   localparam int PADDR_W       = 3;
   localparam int PDATA_W       = 32;

   localparam logic [CFG_W-1:0] SPACING_RESET = 16'd300;
   localparam logic [CFG_W-1:0] STEPS_RESET   = 16'd2844;

   localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 16'sd23040;

   // Register select: byte address bit 2 picks the register.
   localparam logic REG_SPACING = 1'b0;
   localparam logic REG_STEPS   = 1'b1;

   // atan(2^-i) in degrees, scaled by 2^16.
   localparam logic signed [Z_W-1:0] ATAN_TABLE [ATAN_ENTRIES] = '{
      25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
      25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
      25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
      25'sd917,     25'sd458,     25'sd229,    25'sd115,
      25'sd57,      25'sd29,      25'sd14,     25'sd7,
      25'sd4,       25'sd2,       25'sd1,      25'sd0
   };

   typedef struct packed {
      logic [DIST_W-1:0] first_distance;
      logic [DIST_W-1:0] second_distance;
   } req_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] skew_angle;
      logic [COUNT_W-1:0]        turn_count;
      logic                      clockwise;
   } rsp_type;

   typedef struct packed {
      logic d_zero;
      logic d_pos;
      logic sp_zero;
   } flag_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      flag_type               flags;
   } cordic_type;

endpackage

`default_nettype wire

// ===== src/sstc_prep.sv =====
// Front stage: difference of the two readings and CORDIC start vector.
// Depends on sstc_pkg.
`default_nettype none

module sstc_prep (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  wire sstc_pkg::req_type             req_data,
   input  wire logic [sstc_pkg::CFG_W-1:0]    spacing,
   output logic                               valid_ff,
   output sstc_pkg::cordic_type               stage_ff
);

   logic signed [sstc_pkg::DIST_W:0]   diff;
   logic signed [sstc_pkg::XY_W-1:0]   y_wide;
   sstc_pkg::cordic_type               stage_in;

   always_comb begin
      diff   = $signed({1'b0, req_data.first_distance})
             - $signed({1'b0, req_data.second_distance});
      y_wide = sstc_pkg::XY_W'(diff);
      stage_in.x = $signed(sstc_pkg::XY_W'(spacing)) <<< sstc_pkg::FRAC_SHIFT;
      stage_in.y = y_wide <<< sstc_pkg::FRAC_SHIFT;
      stage_in.z = '0;
      stage_in.flags.d_zero  = (diff == '0);
      stage_in.flags.d_pos   = (diff > 0);
      stage_in.flags.sp_zero = (spacing == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

endmodule

`default_nettype wire

// ===== src/sstc_cell.sv =====
// One CORDIC vectoring rotation with its pipeline register.
// Depends on sstc_pkg.
`default_nettype none

module sstc_cell #(
   parameter int STAGE = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  valid_prev,
   input  wire sstc_pkg::cordic_type  stage_prev,
   output logic                       valid_ff,
   output sstc_pkg::cordic_type       stage_ff
);

   logic signed [sstc_pkg::XY_W-1:0] x_cur;
   logic signed [sstc_pkg::XY_W-1:0] y_cur;
   logic signed [sstc_pkg::XY_W-1:0] xs;
   logic signed [sstc_pkg::XY_W-1:0] ys;
   sstc_pkg::cordic_type             stage_in;

   always_comb begin
      x_cur = stage_prev.x;
      y_cur = stage_prev.y;
      xs    = x_cur >>> STAGE;
      ys    = y_cur >>> STAGE;
      stage_in.flags = stage_prev.flags;
      // Rotate toward y = 0.
      if (y_cur > 0) begin
         stage_in.x = x_cur + ys;
         stage_in.y = y_cur - xs;
         stage_in.z = stage_prev.z + sstc_pkg::ATAN_TABLE[STAGE];
      end else begin
         stage_in.x = x_cur - ys;
         stage_in.y = y_cur + xs;
         stage_in.z = stage_prev.z - sstc_pkg::ATAN_TABLE[STAGE];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_prev;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

endmodule

`default_nettype wire

// ===== src/sstc_post.sv =====
// Back end: round and clamp the angle, then scale its magnitude to a turn count.
// Depends on sstc_pkg.
`default_nettype none

module sstc_post (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        valid_prev,
   input  wire sstc_pkg::cordic_type        stage_prev,
   input  wire logic [sstc_pkg::CFG_W-1:0]  steps,
   output logic                             rsp_valid_ff,
   output sstc_pkg::rsp_type                rsp_ff
);

   localparam int RND_W = sstc_pkg::Z_W - sstc_pkg::ROUND_SHIFT;
   localparam int PROD_W = sstc_pkg::COUNT_W + sstc_pkg::CFG_W;

   logic signed [sstc_pkg::Z_W-1:0]     z_sum;
   logic signed [sstc_pkg::Z_W-1:0]     z_shift;
   logic signed [RND_W-1:0]             z_rnd;
   logic signed [sstc_pkg::ANGLE_W-1:0] angle_in;
   logic signed [sstc_pkg::ANGLE_W-1:0] angle_ff;
   logic                                angle_valid_ff;
   logic [sstc_pkg::ANGLE_W-1:0]        mag_full;
   logic [sstc_pkg::COUNT_W-1:0]        mag;
   logic [PROD_W-1:0]                   prod;
   sstc_pkg::rsp_type                   rsp_in;

   always_comb begin
      z_sum   = stage_prev.z + sstc_pkg::Z_W'(128);
      z_shift = z_sum >>> sstc_pkg::ROUND_SHIFT;
      z_rnd   = z_shift[RND_W-1:0];
      if (stage_prev.flags.d_zero) begin
         angle_in = '0;
      end else if (stage_prev.flags.sp_zero) begin
         angle_in = stage_prev.flags.d_pos ? sstc_pkg::ANGLE_LIMIT : -sstc_pkg::ANGLE_LIMIT;
      end else if (z_rnd > sstc_pkg::ANGLE_LIMIT) begin
         angle_in = sstc_pkg::ANGLE_LIMIT;
      end else if (z_rnd < -sstc_pkg::ANGLE_LIMIT) begin
         angle_in = -sstc_pkg::ANGLE_LIMIT;
      end else begin
         angle_in = z_rnd[sstc_pkg::ANGLE_W-1:0];
      end
   end

   always_comb begin
      mag_full = angle_ff[sstc_pkg::ANGLE_W-1] ? -angle_ff : angle_ff;
      mag      = mag_full[sstc_pkg::COUNT_W-1:0];
      prod     = mag * steps;
      rsp_in.skew_angle = angle_ff;
      rsp_in.turn_count = prod[PROD_W-1:sstc_pkg::CFG_W];
      rsp_in.clockwise  = (angle_ff > 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         angle_valid_ff <= valid_prev;
         rsp_valid_ff   <= angle_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      angle_ff <= angle_in;
      rsp_ff   <= rsp_in;
   end

endmodule

`default_nettype wire

// ===== src/sensor_skew_to_turn_command_unit.sv =====
// Top level of the sensor skew to turn command unit.
// Depends on sstc_pkg, sstc_prep, sstc_cell and sstc_post.
`default_nettype none

// Takes a pair of distance readings each cycle and returns the skew angle
// atan((first - second) / spacing) in signed Q7.8 degrees, the turn count
// |angle| * steps_per_degree (Q8.8) truncated, and a clockwise flag that is
// set only for a strictly positive angle. The unit is a fully pipelined
// CORDIC: one beat enters every cycle (busy never rises). The edge that
// takes start also loads the front stage; each beat then passes through
// CORDIC_STAGES + 3 registers in all (one front stage, one cell per CORDIC
// rotation, two back-end stages for rounding and the multiply) before its
// result appears on the rsp_ ports, marked by rsp_valid.
// The result is shown for one cycle only; the receiver cannot stall it, so
// it must take every beat. Write the two APB registers only while no beat
// is in flight: spacing at byte address 0, steps per degree at address 4.

module sensor_skew_to_turn_command_unit #(
   parameter int CORDIC_STAGES = sstc_pkg::CORDIC_STAGES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Input channel
   input  wire logic                              start,
   output logic                                   busy,
   input  wire sstc_pkg::req_type                 req_data,
   // Result channel
   output logic                                   rsp_valid,
   output sstc_pkg::rsp_type                      rsp_data,
   // APB configuration port
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [sstc_pkg::PADDR_W-1:0]      paddr,
   input  wire logic [sstc_pkg::PDATA_W-1:0]      pwdata,
   output logic [sstc_pkg::PDATA_W-1:0]           prdata,
   output logic                                   pready
);

   logic [sstc_pkg::CFG_W-1:0] spacing_ff;
   logic [sstc_pkg::CFG_W-1:0] steps_ff;
   logic                       csr_write;
   logic                       load;

   // Pipeline links: entry 0 is the front stage, entry N the last cell.
   logic                 link_valid [CORDIC_STAGES+1];
   sstc_pkg::cordic_type link_stage [CORDIC_STAGES+1];

   // The pipeline never stalls, so a beat is taken whenever start is high.
   assign busy   = 1'b0;
   assign load   = start & ~busy;
   assign pready = 1'b1;

   // Register file: decode on address bit 2, keep the low 16 bits of data.
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff <= sstc_pkg::SPACING_RESET;
         steps_ff   <= sstc_pkg::STEPS_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            sstc_pkg::REG_SPACING: spacing_ff <= pwdata[sstc_pkg::CFG_W-1:0];
            sstc_pkg::REG_STEPS:   steps_ff   <= pwdata[sstc_pkg::CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         sstc_pkg::REG_SPACING: prdata = sstc_pkg::PDATA_W'(spacing_ff);
         sstc_pkg::REG_STEPS:   prdata = sstc_pkg::PDATA_W'(steps_ff);
         default:               prdata = '0;
      endcase
   end

   // Front stage: difference and start vector (x = spacing, y = difference).
   sstc_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .req_data (req_data),
      .spacing  (spacing_ff),
      .valid_ff (link_valid[0]),
      .stage_ff (link_stage[0])
   );

   // Row of rotation cells; each hands its vector to the next every cycle.
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      sstc_cell #(
         .STAGE (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .valid_prev (link_valid[i]),
         .stage_prev (link_stage[i]),
         .valid_ff   (link_valid[i+1]),
         .stage_ff   (link_stage[i+1])
      );
   end

   // Back end: round, clamp, apply special cases, then scale to a turn count.
   sstc_post u_post (
      .clock        (clock),
      .reset        (reset),
      .valid_prev   (link_valid[CORDIC_STAGES]),
      .stage_prev   (link_stage[CORDIC_STAGES]),
      .steps        (steps_ff),
      .rsp_valid_ff (rsp_valid),
      .rsp_ff       (rsp_data)
   );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for sensor_skew_to_turn_command_unit: random and directed
// sensor pairs against a cycle-free CORDIC arctangent predictor in this file.
// Depends on sstc_pkg (payload structs, widths, register select) and the unit.
`timescale 1ns / 1ps

module tb_top;

   // Pipeline depth as stated at the head of the unit: front stage, one cell
   // per rotation, two back-end stages.
   localparam int SKEW_STAGES   = sstc_pkg::CORDIC_STAGES;
   localparam int PIPE_LATENCY  = SKEW_STAGES + 3;
   localparam int SETTLE_CYCLES = PIPE_LATENCY + 4;
   localparam int STALL_LIMIT   = 1000;
   localparam int RANDOM_PER_PHASE = 70;

   localparam logic [sstc_pkg::PADDR_W-1:0] SPACING_ADDR = {sstc_pkg::REG_SPACING, 2'b00};
   localparam logic [sstc_pkg::PADDR_W-1:0] STEPS_ADDR   = {sstc_pkg::REG_STEPS, 2'b00};

   localparam longint QUARTER_TURN_Q16 = 64'sd5898240;
   localparam longint ANGLE_CLAMP_Q8   = 64'sd23040;

   // atan(2^-i) in degrees with 16 fraction bits, rounded to nearest.
   localparam longint ARCTAN_DEG_Q16 [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   // ------------------------------------------------------------------
   // Clock, reset and stimulus-side signals (all known from time zero)
   // ------------------------------------------------------------------
   logic                          clock    = 1'b0;
   logic                          reset    = 1'b1;
   logic                          start    = 1'b0;
   sstc_pkg::req_type             req_data = '0;
   logic                          psel     = 1'b0;
   logic                          penable  = 1'b0;
   logic                          pwrite   = 1'b0;
   logic [sstc_pkg::PADDR_W-1:0]  paddr    = '0;
   logic [sstc_pkg::PDATA_W-1:0]  pwdata   = '0;

   logic                          busy;
   logic                          rsp_valid;
   sstc_pkg::rsp_type             rsp_data;
   logic [sstc_pkg::PDATA_W-1:0]  prdata;
   logic                          pready;

   sensor_skew_to_turn_command_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Shadow copy of the two registers and the bench's queues
   // ------------------------------------------------------------------
   logic [sstc_pkg::CFG_W-1:0] spacing_shadow = sstc_pkg::SPACING_RESET;
   logic [sstc_pkg::CFG_W-1:0] steps_shadow   = sstc_pkg::STEPS_RESET;

   sstc_pkg::req_type pending_pairs[$];      // sensor pairs not yet presented
   sstc_pkg::rsp_type expected_commands[$];  // turn commands owed by the pipeline
   int      mismatch_count = 0;

   // Sender idling: 0 turns bursts off, otherwise a burst starts with
   // odds of one in idle_odds whenever a new beat could be presented.
   int      idle_odds  = 4;
   int      idle_left  = 0;

   // ------------------------------------------------------------------
   // Predictor: vectoring CORDIC on x = spacing, y = difference, all
   // arithmetic in 64-bit signed so no intermediate can wrap. Arithmetic
   // right shift of a signed longint is a floor shift, as required.
   // ------------------------------------------------------------------
   function automatic sstc_pkg::rsp_type predict_turn_command(sstc_pkg::req_type pair);
      longint  first_val;
      longint  second_val;
      longint  diff;
      longint  x;
      longint  y;
      longint  z;
      longint  xs;
      longint  ys;
      longint  angle;
      longint  mag;
      longint  steps;
      longint  count;
      sstc_pkg::rsp_type cmd;
      first_val  = longint'(pair.first_distance);
      second_val = longint'(pair.second_distance);
      steps      = longint'(steps_shadow);
      diff       = first_val - second_val;
      angle      = 0;
      z          = 0;
      if (diff != 0) begin
         if (spacing_shadow == '0) begin
            // No baseline: the skew is a full quarter turn either way.
            z = (diff > 0) ? QUARTER_TURN_Q16 : -QUARTER_TURN_Q16;
         end else begin
            x = longint'(spacing_shadow);
            x = x * 65536;
            y = diff * 65536;
            for (int i = 0; i < SKEW_STAGES && i < 24; i++) begin
               xs = x >>> i;
               ys = y >>> i;
               // Rotate toward y = 0; y of exactly zero counts as "not above".
               if (y > 0) begin
                  x = x + ys;
                  y = y - xs;
                  z = z + ARCTAN_DEG_Q16[i];
               end else begin
                  x = x - ys;
                  y = y + xs;
                  z = z - ARCTAN_DEG_Q16[i];
               end
            end
         end
         // Round half up to Q7.8, then clamp to +-90 degrees.
         angle = (z + 128) >>> 8;
         if (angle > ANGLE_CLAMP_Q8)
            angle = ANGLE_CLAMP_Q8;
         if (angle < -ANGLE_CLAMP_Q8)
            angle = -ANGLE_CLAMP_Q8;
      end
      mag   = (angle < 0) ? -angle : angle;
      count = (mag * steps) >>> 16;
      cmd.skew_angle = angle[sstc_pkg::ANGLE_W-1:0];
      cmd.turn_count = count[sstc_pkg::COUNT_W-1:0];
      cmd.clockwise  = (angle > 0);
      return cmd;
   endfunction

   // ------------------------------------------------------------------
   // Driver: present one beat at a time from pending_pairs. Hold start and
   // the payload while busy is high; between beats insert random idle bursts.
   // Exactly one nonblocking write per signal per edge, so a back-to-back
   // beat keeps start high without a glitch.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start     <= 1'b0;
         idle_left = 0;
      end else if (start && busy) begin
         // Hold: the current beat has not been taken yet.
      end else if (idle_left > 0) begin
         idle_left = idle_left - 1;
         start     <= 1'b0;
      end else if (pending_pairs.size() != 0) begin
         if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
            idle_left = $urandom_range(1, 10) - 1;
            start     <= 1'b0;
         end else begin
            req_data <= pending_pairs.pop_front();
            start    <= 1'b1;
         end
      end else begin
         start <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: predict on every accepted beat, check every strobed result
   // against the oldest expectation, field by field. Values read here are
   // the ones from before this edge, so ordering within the step is moot.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      sstc_pkg::rsp_type want;
      if (!reset) begin
         if (start && !busy)
            expected_commands.push_back(predict_turn_command(req_data));
         if (rsp_valid) begin
            if (expected_commands.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result beat, actual %p", $time, rsp_data);
            end else begin
               want = expected_commands.pop_front();
               if (rsp_data.skew_angle !== want.skew_angle) begin
                  mismatch_count++;
                  $display("%0t: skew_angle expected %0d actual %0d", $time,
                           want.skew_angle, rsp_data.skew_angle);
               end
               if (rsp_data.turn_count !== want.turn_count) begin
                  mismatch_count++;
                  $display("%0t: turn_count expected %0d actual %0d", $time,
                           want.turn_count, rsp_data.turn_count);
               end
               if (rsp_data.clockwise !== want.clockwise) begin
                  mismatch_count++;
                  $display("%0t: clockwise expected %0b actual %0b", $time,
                           want.clockwise, rsp_data.clockwise);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: count cycles with no accepted beat, no result and no
   // register access; give up when the count reaches the limit.
   // ------------------------------------------------------------------
   int stall_cycles = 0;

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable && pready))
         stall_cycles = 0;
      else
         stall_cycles = stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic push_pair(input logic [sstc_pkg::DIST_W-1:0] first_d,
                            input logic [sstc_pkg::DIST_W-1:0] second_d);
      sstc_pkg::req_type pair;
      pair.first_distance  = first_d;
      pair.second_distance = second_d;
      pending_pairs.push_back(pair);
   endtask

   // Mix of pair shapes: plain random, equal readings, tiny differences,
   // differences near zero to four multiples of the spacing (angles spread
   // across most of the range), and corner readings.
   task automatic queue_random_pairs(input int count);
      int unsigned base;
      int unsigned span;
      int unsigned corner [4];
      corner = '{0, 1, 32768, 65535};
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 7))
            0, 1, 2: push_pair(16'($urandom), 16'($urandom));
            3: begin
               base = $urandom_range(0, 65535);
               push_pair(16'(base), 16'(base));
            end
            4: begin
               base = $urandom_range(0, 65535);
               push_pair(16'(base), 16'(base ^ $urandom_range(1, 15)));
            end
            5, 6: begin
               span = spacing_shadow * $urandom_range(0, 4) + $urandom_range(0, 3);
               if (span > 65535)
                  span = $urandom_range(0, 65535);
               base = $urandom_range(0, 65535 - span);
               if ($urandom_range(0, 1))
                  push_pair(16'(base + span), 16'(base));
               else
                  push_pair(16'(base), 16'(base + span));
            end
            default: push_pair(16'(corner[$urandom_range(0, 3)]),
                               16'(corner[$urandom_range(0, 3)]));
         endcase
      end
   endtask

   // Wait until every presented beat is accepted and every result is back,
   // then give the pipeline a little extra time to settle.
   task automatic wait_for_drain();
      while (pending_pairs.size() != 0 || start || expected_commands.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write a register (upper pwdata bits random, only the low 16 matter),
   // update the shadow copy at the write edge, then read it back.
   task automatic write_register(input logic [sstc_pkg::PADDR_W-1:0] addr,
                                 input logic [sstc_pkg::CFG_W-1:0] value);
      logic [sstc_pkg::PDATA_W-1:0] readback;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= {16'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == SPACING_ADDR)
         spacing_shadow = value;
      else
         steps_shadow = value;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      psel    <= 1'b1;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback[sstc_pkg::CFG_W-1:0] !== value) begin
         mismatch_count++;
         $display("%0t: register at %0d expected %0d actual %0d", $time, addr,
                  value, readback[sstc_pkg::CFG_W-1:0]);
      end
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   logic [sstc_pkg::CFG_W-1:0] spacing_plan [6];
   logic [sstc_pkg::CFG_W-1:0] steps_plan [6];

   initial begin
      // Phases after the reset-value phase: zero spacing, the smallest and
      // largest values, two random settings, and back to the reset values.
      spacing_plan = '{16'd0, 16'd1, 16'd65535, 16'($urandom_range(1, 65535)),
                       16'($urandom_range(1, 64)), sstc_pkg::SPACING_RESET};
      steps_plan   = '{16'd65535, 16'd1, 16'd0, 16'($urandom_range(1, 65535)),
                       16'($urandom_range(1, 65535)), sstc_pkg::STEPS_RESET};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset values in force: equal readings, extreme readings, 45 degrees
      // both ways, one-count differences and the midscale neighbors.
      push_pair(16'd0, 16'd0);
      push_pair(16'd65535, 16'd65535);
      push_pair(16'd1234, 16'd1234);
      push_pair(16'd65535, 16'd0);
      push_pair(16'd0, 16'd65535);
      push_pair(16'd1, 16'd0);
      push_pair(16'd0, 16'd1);
      push_pair(16'd300, 16'd0);
      push_pair(16'd0, 16'd300);
      push_pair(16'd600, 16'd300);
      push_pair(16'd150, 16'd0);
      push_pair(16'd32768, 16'd32767);
      push_pair(16'd32767, 16'd32768);
      push_pair(16'd43690, 16'd21845);
      queue_random_pairs(RANDOM_PER_PHASE);
      wait_for_drain();

      for (int p = 0; p < 6; p++) begin
         write_register(SPACING_ADDR, spacing_plan[p]);
         write_register(STEPS_ADDR, steps_plan[p]);
         // One phase runs with no idling at all; the last phase too.
         if (p == 2 || p == 5)
            idle_odds = 0;
         else
            idle_odds = $urandom_range(2, 6);
         case (p)
            0: begin
               // Zero spacing: full quarter turns, and equal readings stay 0.
               push_pair(16'd5, 16'd0);
               push_pair(16'd0, 16'd5);
               push_pair(16'd7, 16'd7);
            end
            2: begin
               // Widest spacing: one-count differences round to a zero angle.
               push_pair(16'd1, 16'd0);
               push_pair(16'd0, 16'd1);
            end
            default: ;
         endcase
         queue_random_pairs(RANDOM_PER_PHASE);
         wait_for_drain();
      end

      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/sstc_pkg.sv
src/sstc_prep.sv
src/sstc_cell.sv
src/sstc_post.sv
src/sensor_skew_to_turn_command_unit.sv
bench/tb_top.sv
